>>> hdl/rcfft_pkg.sv
// Shared types and constants of the radix-2 complex FFT block.
`default_nettype none
package rcfft_pkg;

   // Internal word of the sample store
   localparam int STORE_BITS = 28;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOG2_POINTS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERSE     = 1'd1;
   localparam logic [CSR_DATA_BITS-1:0]  LOG2_POINTS_RESET = 4'd10;

   // Request commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Output scaling: Q16 factor, 1/sqrt(2) for odd log2 lengths
   localparam int SCALE_BITS = 18;
   localparam int SCALE_FRAC = 16;
   localparam logic signed [SCALE_BITS-1:0] UNIT_Q16      = 18'sd65536;
   localparam logic signed [SCALE_BITS-1:0] INV_SQRT2_Q16 = 18'sd46341;

   typedef enum logic [2:0] {
      XF_IDLE,
      XF_SWAP,
      XF_SWAP_WAIT,
      XF_BFLY,
      XF_BFLY_WAIT
   } xform_state_type;

endpackage
`default_nettype wire

>>> hdl/rcfft_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none
module rcfft_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr_a,
   output logic      [WIDTH-1:0]         read_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr_b,
   output logic      [WIDTH-1:0]         read_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read-first: a read at the write address returns the old word
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_a <= mem[read_addr_a];
      read_data_b <= mem[read_addr_b];
   end

endmodule
`default_nettype wire

>>> hdl/rcfft_twiddle.sv
// Twiddle factor ROM: quarter-wave cosine table and registered lookup.
`default_nettype none
module rcfft_twiddle #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 18
) (
   input  wire logic clock,
   input  wire logic twiddle_load,
   input  wire logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] twiddle_index,
   input  wire logic inverse,
   output logic signed [TWIDDLE_BITS-1:0] twiddle_cos,
   output logic signed [TWIDDLE_BITS-1:0] twiddle_sin
);

   localparam int LOG_MAX = $clog2(MAX_POINTS);
   localparam int KW      = (LOG_MAX > 1) ? LOG_MAX - 1 : 1;
   localparam int QUARTER = MAX_POINTS / 4;
   localparam int QW      = (QUARTER > 0) ? $clog2(QUARTER + 1) : 1;
   localparam int RSH     = 32 - TWIDDLE_BITS;
   localparam longint X_DEN   = (QUARTER > 0) ? 2 * QUARTER : 1;
   localparam longint PI_Q30  = 64'sd3373259426;
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint COS_DIV [14] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
                                       462, 552, 650, 756};

   // cos(pi/2 * k/QUARTER) by Taylor series in Q30, clamped, rounded to twiddle format
   function automatic longint quarter_cos(input int k);
      longint x;
      longint x2;
      longint sum;
      longint term;
      longint c;
      x    = (QUARTER > 0) ? (PI_Q30 * longint'(k)) / X_DEN : 64'sd0;
      x2   = (x * x) >>> 30;
      sum  = Q30_ONE;
      term = Q30_ONE;
      for (int n = 0; n < 14; n++) begin
         term = -((term * x2) / Q30_ONE) / COS_DIV[n];
         sum  = sum + term;
      end
      c = sum;
      if (c < 0) c = 0;
      if (c > Q30_ONE) c = Q30_ONE;
      if (RSH > 0) c = (c + (64'sd1 <<< (RSH - 1))) >>> RSH;
      return c;
   endfunction

   logic signed [TWIDDLE_BITS-1:0] rom [QUARTER+1];
   logic signed [TWIDDLE_BITS-1:0] cos_in;
   logic signed [TWIDDLE_BITS-1:0] sin_mag;
   logic signed [TWIDDLE_BITS-1:0] twiddle_cos_ff;
   logic signed [TWIDDLE_BITS-1:0] twiddle_sin_ff;

   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      assign rom[g] = TWIDDLE_BITS'(quarter_cos(g));
   end

   if (QUARTER == 0) begin : g_tiny
      always_comb begin
         cos_in  = rom[0];
         sin_mag = '0;
      end
   end else begin : g_full
      always_comb begin
         if (int'(twiddle_index) <= QUARTER) begin
            cos_in  = rom[QW'(int'(twiddle_index))];
            sin_mag = rom[QW'(QUARTER - int'(twiddle_index))];
         end else begin
            cos_in  = -rom[QW'(2 * QUARTER - int'(twiddle_index))];
            sin_mag = rom[QW'(int'(twiddle_index) - QUARTER)];
         end
      end
   end

   // forward transform uses the negative exponent
   always_ff @(posedge clock) begin
      if (twiddle_load) begin
         twiddle_cos_ff <= cos_in;
         twiddle_sin_ff <= inverse ? sin_mag : -sin_mag;
      end
   end

   assign twiddle_cos = twiddle_cos_ff;
   assign twiddle_sin = twiddle_sin_ff;

endmodule
`default_nettype wire

>>> hdl/radix2_complex_fft_top.sv
// Radix-2 in-place complex FFT with unitary scaling, top level.
//
// Request beats carry a command: load writes the next sample, drain asks for
// the next bin. The load that completes 2^log2_points samples (log2_points
// clamped to 1..log2(MAX_POINTS)) starts the transform; drains then return
// bins in natural order, one response beat per drain, with last_bin on the
// final one. A drain with no finished frame is taken and gives no response.
// csr_ writes set the length and direction; the user must make them only
// while the block is idle, as the block itself does not enforce it. A drain
// passes through the store read, the scaling product and the response
// register. The transform holds req_stall while it runs: the store RAMs have
// one write port, so each butterfly writes its two results one after the
// other, and every pass waits for the butterfly pipeline to empty.
// The response register holds one beat; loads go on while it waits, and a
// drain stalls until it is taken. Reset clears counters and state and sets
// log2_points to 10 and direction to forward; store contents are not cleared.
`default_nettype none
module radix2_complex_fft_top #(
   parameter int MAX_POINTS   = 1024,
   parameter int SAMPLE_BITS  = 16,
   parameter int TWIDDLE_BITS = 18
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [rcfft_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcfft_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic req_command,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_real,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_imag,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_result_real,
   output logic signed [SAMPLE_BITS-1:0] rsp_result_imag,
   output logic [9:0] rsp_bin_index,
   output logic       rsp_last_bin,
   output logic       rsp_saturated
);

   localparam int LOG_MAX = $clog2(MAX_POINTS);
   localparam int AW      = LOG_MAX;
   localparam int CW      = LOG_MAX + 1;
   localparam int KW      = (LOG_MAX > 1) ? LOG_MAX - 1 : 1;
   localparam int ULW     = $clog2(LOG_MAX + 1);
   localparam int SGW     = (LOG_MAX > 1) ? $clog2(LOG_MAX) : 1;
   localparam int SW      = rcfft_pkg::STORE_BITS;
   localparam int PW      = SW + TWIDDLE_BITS;
   localparam int RND     = TWIDDLE_BITS - 2;
   localparam int DW      = SW + rcfft_pkg::SCALE_BITS;
   localparam int SHW     = $clog2(rcfft_pkg::SCALE_FRAC + LOG_MAX / 2 + 1);
   localparam logic [SGW-1:0] TOP_STAGE = SGW'(LOG_MAX - 1);
   localparam logic signed [PW:0] BF_HALF = (PW+1)'(1) <<< (RND - 1);
   localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [DW-1:0] SAT_LO = DW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
      logic [AW-1:0] r;
      for (int b = 0; b < AW; b++) begin
         r[b] = v[AW-1-b];
      end
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [rcfft_pkg::CSR_DATA_BITS-1:0] log2_points_ff;
   logic                                inverse_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_points_ff  <= rcfft_pkg::LOG2_POINTS_RESET;
         inverse_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            rcfft_pkg::CSR_LOG2_POINTS: log2_points_ff  <= csr_data;
            rcfft_pkg::CSR_INVERSE:     inverse_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [ULW-1:0] used_l;
   logic [CW-1:0]  n_cur;

   always_comb begin
      if (log2_points_ff == '0) begin
         used_l = ULW'(1);
      end else if (int'(log2_points_ff) > LOG_MAX) begin
         used_l = ULW'(LOG_MAX);
      end else begin
         used_l = ULW'(log2_points_ff);
      end
      n_cur = CW'(1) << used_l;
   end

   // ---------------- state ----------------
   rcfft_pkg::xform_state_type xf_state_ff, xf_state_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [SGW-1:0] stage_ff, stage_in;
   logic           phase_ff, phase_in;
   logic [ULW-1:0] lt_ff;
   logic           inv_ff;
   logic [CW-1:0]  load_count_ff, load_count_in;
   logic [CW-1:0]  drain_count_ff, drain_count_in;
   logic           results_ready_ff, results_ready_in;

   // butterfly pipeline
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic swap1_ff, swap2_ff, swap3_ff;
   logic [AW-1:0] a1_ff, a2_ff, a3_ff, b1_ff, b2_ff, b3_ff, b4_ff;
   logic signed [SW-1:0] xa_re_ff, xa_im_ff, xb_re_ff, xb_im_ff;
   logic signed [PW-1:0] p1_ff, p2_ff, q3_ff, q4_ff;
   logic signed [SW-1:0] tr_ff;
   logic signed [SW-1:0] wb_re_ff, wb_im_ff;

   // drain pipeline
   logic dv1_ff, dv2_ff;
   logic [ULW-1:0] dl1_ff, dl2_ff;
   logic dlast1_ff, dlast2_ff;
   logic [AW-1:0] didx1_ff, didx2_ff;
   logic signed [DW-1:0] dprod_re_ff, dprod_im_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_real_ff, rsp_imag_ff;
   logic [9:0] rsp_bin_ff;
   logic rsp_last_ff, rsp_sat_ff;

   // ---------------- request side ----------------
   logic req_fire, load_fire, drain_fire, start_xf;
   logic [CW-1:0] load_inc;
   logic          drain_last;

   assign req_stall = (xf_state_ff != rcfft_pkg::XF_IDLE) || dv1_ff || dv2_ff
                      || (req_command == rcfft_pkg::CMD_DRAIN && rsp_valid_ff);
   assign req_fire   = req_valid && !req_stall;
   assign load_fire  = req_fire && (req_command == rcfft_pkg::CMD_LOAD);
   assign drain_fire = req_fire && (req_command == rcfft_pkg::CMD_DRAIN) && results_ready_ff;
   assign load_inc   = load_count_ff + CW'(1);
   assign start_xf   = load_fire && (load_inc >= n_cur);
   assign drain_last = (drain_count_ff + CW'(1)) >= n_cur;

   always_comb begin
      load_count_in    = load_count_ff;
      drain_count_in   = drain_count_ff;
      results_ready_in = results_ready_ff;
      if (load_fire) begin
         if (results_ready_ff) begin
            results_ready_in = 1'b0;
            drain_count_in   = '0;
         end
         load_count_in = load_inc;
         if (start_xf) begin
            load_count_in    = '0;
            drain_count_in   = '0;
            results_ready_in = 1'b1;
         end
      end else if (drain_fire) begin
         if (drain_last) begin
            results_ready_in = 1'b0;
            drain_count_in   = '0;
         end else begin
            drain_count_in = drain_count_ff + CW'(1);
         end
      end
   end

   // ---------------- transform sequencer ----------------
   logic [CW-1:0]  n_xf;
   logic [AW-1:0]  swap_r;
   logic [AW-1:0]  low_mask, bf_j, bf_a, bf_b, k_full;
   logic [SGW-1:0] k_shift;
   logic           pipe_empty;
   logic           issue;
   logic           issue_swap;
   logic [AW-1:0]  issue_a, issue_b;
   logic [KW-1:0]  tw_k;

   assign n_xf       = CW'(1) << lt_ff;
   assign pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff);
   assign swap_r     = bit_rev(pos_ff) >> (ULW'(LOG_MAX) - lt_ff);
   assign low_mask   = (AW'(1) << stage_ff) - AW'(1);
   assign bf_j       = pos_ff & low_mask;
   assign bf_a       = ((pos_ff >> stage_ff) << (stage_ff + SGW'(1))) | bf_j;
   assign bf_b       = bf_a | (AW'(1) << stage_ff);
   assign k_shift    = TOP_STAGE - stage_ff;
   assign k_full     = bf_j << k_shift;
   assign tw_k       = k_full[KW-1:0];

   always_comb begin
      xf_state_in = xf_state_ff;
      pos_in      = pos_ff;
      stage_in    = stage_ff;
      phase_in    = 1'b0;
      issue       = 1'b0;
      issue_swap  = 1'b0;
      issue_a     = bf_a;
      issue_b     = bf_b;
      case (xf_state_ff)
         rcfft_pkg::XF_IDLE: begin
            if (start_xf) begin
               xf_state_in = rcfft_pkg::XF_SWAP;
               pos_in      = '0;
            end
         end
         rcfft_pkg::XF_SWAP: begin
            issue_a  = pos_ff;
            issue_b  = swap_r;
            phase_in = !phase_ff;
            if (!phase_ff) begin
               issue      = pos_ff < swap_r;
               issue_swap = 1'b1;
               if (pos_ff == AW'(n_xf - CW'(1))) begin
                  xf_state_in = rcfft_pkg::XF_SWAP_WAIT;
               end else begin
                  pos_in = pos_ff + AW'(1);
               end
            end
         end
         rcfft_pkg::XF_SWAP_WAIT: begin
            if (pipe_empty) begin
               xf_state_in = rcfft_pkg::XF_BFLY;
               pos_in      = '0;
               stage_in    = '0;
            end
         end
         rcfft_pkg::XF_BFLY: begin
            phase_in = !phase_ff;
            if (!phase_ff) begin
               issue = 1'b1;
               if (pos_ff == AW'((n_xf >> 1) - CW'(1))) begin
                  xf_state_in = rcfft_pkg::XF_BFLY_WAIT;
               end else begin
                  pos_in = pos_ff + AW'(1);
               end
            end
         end
         rcfft_pkg::XF_BFLY_WAIT: begin
            // next pass reads what this pass wrote: wait for the last write
            if (pipe_empty) begin
               if (stage_ff == SGW'(lt_ff - ULW'(1))) begin
                  xf_state_in = rcfft_pkg::XF_IDLE;
               end else begin
                  xf_state_in = rcfft_pkg::XF_BFLY;
                  stage_in    = stage_ff + SGW'(1);
                  pos_in      = '0;
               end
            end
         end
         default: xf_state_in = rcfft_pkg::XF_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xf_state_ff      <= rcfft_pkg::XF_IDLE;
         phase_ff         <= 1'b0;
         load_count_ff    <= '0;
         drain_count_ff   <= '0;
         results_ready_ff <= 1'b0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         v4_ff            <= 1'b0;
         dv1_ff           <= 1'b0;
         dv2_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         xf_state_ff      <= xf_state_in;
         phase_ff         <= phase_in;
         load_count_ff    <= load_count_in;
         drain_count_ff   <= drain_count_in;
         results_ready_ff <= results_ready_in;
         v1_ff            <= issue;
         v2_ff            <= v1_ff;
         v3_ff            <= v2_ff;
         v4_ff            <= v3_ff;
         dv1_ff           <= drain_fire;
         dv2_ff           <= dv1_ff;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      stage_ff <= stage_in;
      if (start_xf) begin
         lt_ff  <= used_l;
         inv_ff <= inverse_mode_ff;
      end
   end

   // ---------------- store ----------------
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr_a;
   logic [SW-1:0] ram_wdata_re, ram_wdata_im;
   logic [SW-1:0] rd_re_a, rd_im_a, rd_re_b, rd_im_b;
   logic signed [SW-1:0] ti_val;
   logic signed [SW-1:0] wa_re, wa_im;
   logic signed [PW:0]   sum_t;
   logic signed [PW:0]   sum_i;

   assign sum_i  = (PW+1)'(q3_ff) + (PW+1)'(q4_ff) + BF_HALF;
   assign ti_val = SW'(sum_i >>> RND);
   assign wa_re  = swap3_ff ? xb_re_ff : xa_re_ff + tr_ff;
   assign wa_im  = swap3_ff ? xb_im_ff : xa_im_ff + ti_val;
   assign sum_t  = (PW+1)'(p1_ff) - (PW+1)'(p2_ff) + BF_HALF;

   always_comb begin
      ram_we       = load_fire || v3_ff || v4_ff;
      ram_waddr    = b4_ff;
      ram_wdata_re = wb_re_ff;
      ram_wdata_im = wb_im_ff;
      if (load_fire) begin
         ram_waddr    = load_count_ff[AW-1:0];
         ram_wdata_re = SW'(req_sample_real);
         ram_wdata_im = SW'(req_sample_imag);
      end else if (v3_ff) begin
         ram_waddr    = a3_ff;
         ram_wdata_re = wa_re;
         ram_wdata_im = wa_im;
      end
      ram_raddr_a = (xf_state_ff == rcfft_pkg::XF_IDLE) ? drain_count_ff[AW-1:0] : issue_a;
   end

   rcfft_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_store_real (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata_re),
      .read_addr_a  (ram_raddr_a),
      .read_data_a  (rd_re_a),
      .read_addr_b  (issue_b),
      .read_data_b  (rd_re_b)
   );

   rcfft_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_store_imag (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata_im),
      .read_addr_a  (ram_raddr_a),
      .read_data_a  (rd_im_a),
      .read_addr_b  (issue_b),
      .read_data_b  (rd_im_b)
   );

   logic signed [TWIDDLE_BITS-1:0] tw_cos, tw_sin;

   rcfft_twiddle #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_twiddle (
      .clock         (clock),
      .twiddle_load  (issue),
      .twiddle_index (tw_k),
      .inverse       (inv_ff),
      .twiddle_cos   (tw_cos),
      .twiddle_sin   (tw_sin)
   );

   // Butterfly: read, re*c/im*s, im*c/re*s, write a, write b
   always_ff @(posedge clock) begin
      swap1_ff <= issue_swap;
      a1_ff    <= issue_a;
      b1_ff    <= issue_b;
      swap2_ff <= swap1_ff;
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
      if (v1_ff) begin
         xa_re_ff <= signed'(rd_re_a);
         xa_im_ff <= signed'(rd_im_a);
         xb_re_ff <= signed'(rd_re_b);
         xb_im_ff <= signed'(rd_im_b);
         p1_ff    <= signed'(rd_re_b) * tw_cos;
         p2_ff    <= signed'(rd_im_b) * tw_sin;
      end
      swap3_ff <= swap2_ff;
      a3_ff    <= a2_ff;
      b3_ff    <= b2_ff;
      if (v2_ff) begin
         q3_ff <= xb_im_ff * tw_cos;
         q4_ff <= xb_re_ff * tw_sin;
         tr_ff <= SW'(sum_t >>> RND);
      end
      b4_ff <= b3_ff;
      if (v3_ff) begin
         wb_re_ff <= swap3_ff ? xa_re_ff : xa_re_ff - tr_ff;
         wb_im_ff <= swap3_ff ? xa_im_ff : xa_im_ff - ti_val;
      end
   end

   // ---------------- drain path ----------------
   logic signed [rcfft_pkg::SCALE_BITS-1:0] scale_factor;
   logic [SHW-1:0]       out_shift;
   logic signed [DW-1:0] round_add, sc_re, sc_im;
   logic                 clip_re, clip_im;
   logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;

   assign scale_factor = dl1_ff[0] ? rcfft_pkg::INV_SQRT2_Q16 : rcfft_pkg::UNIT_Q16;
   assign out_shift    = SHW'(rcfft_pkg::SCALE_FRAC) + SHW'(dl2_ff >> 1);
   assign round_add    = DW'(1) <<< (out_shift - SHW'(1));
   assign sc_re        = (dprod_re_ff + round_add) >>> out_shift;
   assign sc_im        = (dprod_im_ff + round_add) >>> out_shift;

   always_comb begin
      clip_re = 1'b1;
      clip_im = 1'b1;
      if (sc_re > SAT_HI) sat_re = SAMPLE_BITS'(SAT_HI);
      else if (sc_re < SAT_LO) sat_re = SAMPLE_BITS'(SAT_LO);
      else begin
         sat_re  = SAMPLE_BITS'(sc_re);
         clip_re = 1'b0;
      end
      if (sc_im > SAT_HI) sat_im = SAMPLE_BITS'(SAT_HI);
      else if (sc_im < SAT_LO) sat_im = SAMPLE_BITS'(SAT_LO);
      else begin
         sat_im  = SAMPLE_BITS'(sc_im);
         clip_im = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (dv2_ff) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (drain_fire) begin
         dl1_ff    <= used_l;
         dlast1_ff <= drain_last;
         didx1_ff  <= drain_count_ff[AW-1:0];
      end
      if (dv1_ff) begin
         dl2_ff      <= dl1_ff;
         dlast2_ff   <= dlast1_ff;
         didx2_ff    <= didx1_ff;
         dprod_re_ff <= DW'(signed'(rd_re_a) * scale_factor);
         dprod_im_ff <= DW'(signed'(rd_im_a) * scale_factor);
      end
      if (dv2_ff) begin
         rsp_real_ff <= sat_re;
         rsp_imag_ff <= sat_im;
         rsp_bin_ff  <= 10'(didx2_ff);
         rsp_last_ff <= dlast2_ff;
         rsp_sat_ff  <= clip_re || clip_im;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_real = rsp_real_ff;
   assign rsp_result_imag = rsp_imag_ff;
   assign rsp_bin_index   = rsp_bin_ff;
   assign rsp_last_bin    = rsp_last_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // ---------------- checks ----------------
   a_write_port_free: assert property (@(posedge clock) disable iff (reset)
      !(v3_ff && v4_ff))
      else $error("butterfly writes of a and b collide");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (xf_state_ff == rcfft_pkg::XF_IDLE) |-> pipe_empty)
      else $error("transform idle with butterflies in flight");

   a_no_accept_in_xform: assert property (@(posedge clock) disable iff (reset)
      (xf_state_ff != rcfft_pkg::XF_IDLE) |-> !req_fire)
      else $error("request beat accepted during transform");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(dv2_ff))
      else $error("response beat without a drain in the pipeline");

endmodule
`default_nettype wire

>>> tb/sv/tb_radix2_complex_fft_top.sv
// Self-checking testbench for the radix-2 complex FFT top level.
`default_nettype none
module tb_radix2_complex_fft_top;
   import rcfft_pkg::*;

   localparam int NPTS = 1024;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic [9:0]         idx;
      logic               last;
      logic               sat;
   } bin_t;

   typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_BEAT_NONE, ROW_BEAT_BIN} row_kind_t;
   typedef struct {
      row_kind_t          kind;
      logic               cmd;   // or csr index for ROW_CFG
      logic signed [15:0] re;    // or csr data for ROW_CFG
      logic signed [15:0] im;
      bin_t               bin;
   } row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   logic req_valid, req_stall, req_command;
   logic signed [15:0] req_sample_real, req_sample_imag;
   logic rsp_valid, rsp_stall;
   logic signed [15:0] rsp_result_real, rsp_result_imag;
   logic [9:0] rsp_bin_index;
   logic rsp_last_bin, rsp_saturated;

   radix2_complex_fft_top u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_sample_real(req_sample_real), .req_sample_imag(req_sample_imag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_real(rsp_result_real), .rsp_result_imag(rsp_result_imag),
      .rsp_bin_index(rsp_bin_index), .rsp_last_bin(rsp_last_bin),
      .rsp_saturated(rsp_saturated)
   );

   always #10 clock = ~clock;

   // FFT predictor state
   longint cos_rom[NPTS/4+1];
   longint fft_re[NPTS];
   longint fft_im[NPTS];
   int     load_cnt, drain_cnt;
   bit     bins_ready;
   logic [3:0] cfg_log2;
   logic       cfg_inverse;

   bin_t bins_due[$];
   int   err_cnt, n_loads, n_drains, n_bins, n_frames, burst_left, hold_request;

   function automatic longint rnd_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint wrap28(longint v);
      logic signed [27:0] t;
      t = v[27:0];
      return longint'(t);
   endfunction

   function automatic void build_cos_rom();
      longint x, x2, sum, term, c;
      for (int k = 0; k <= NPTS/4; k++) begin
         x = (64'sd3373259426 * k) / (NPTS/2);
         x2 = (x * x) >>> 30;
         sum = 64'sd1 <<< 30;
         term = sum;
         for (int n = 1; n <= 14; n++) begin
            term = -((term * x2) / (64'sd1 <<< 30)) / ((2*n - 1) * (2*n));
            sum += term;
         end
         c = sum < 0 ? 0 : (sum > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : sum);
         cos_rom[k] = rnd_shift(c, 14);
      end
   endfunction

   function automatic int used_log2();
      int l;
      l = cfg_log2;
      if (l < 1) l = 1;
      if (l > 10) l = 10;
      return l;
   endfunction

   function automatic void run_fft(int n, int l);
      int r, q;
      longint tr, ti, ar, ai, c, s;
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int b = 0; b < l; b++) r |= ((i >> b) & 1) << (l - 1 - b);
         if (i < r) begin
            tr = fft_re[r]; ti = fft_im[r];
            fft_re[r] = fft_re[i]; fft_im[r] = fft_im[i];
            fft_re[i] = tr; fft_im[i] = ti;
         end
      end
      for (int half = 1; half < n; half *= 2)
         for (int j = 0; j < half; j++) begin
            q = j * ((NPTS/2) / half);
            if (q <= NPTS/4) begin
               c = cos_rom[q]; s = cos_rom[NPTS/4 - q];
            end else begin
               c = -cos_rom[NPTS/2 - q]; s = cos_rom[q - NPTS/4];
            end
            if (!cfg_inverse) s = -s;
            for (int i = j; i < n; i += 2*half) begin
               tr = rnd_shift(fft_re[i+half] * c - fft_im[i+half] * s, 16);
               ti = rnd_shift(fft_im[i+half] * c + fft_re[i+half] * s, 16);
               ar = fft_re[i]; ai = fft_im[i];
               fft_re[i+half] = wrap28(ar - tr);
               fft_im[i+half] = wrap28(ai - ti);
               fft_re[i] = wrap28(ar + tr);
               fft_im[i] = wrap28(ai + ti);
            end
         end
   endfunction

   function automatic logic signed [15:0] scale_bin(longint v, int l, inout logic sat);
      longint r;
      r = (l % 2) ? rnd_shift(v * 46341, 16 + l/2) : rnd_shift(v, l/2);
      if (r > 32767) begin sat = 1'b1; r = 32767; end
      else if (r < -32768) begin sat = 1'b1; r = -32768; end
      return r[15:0];
   endfunction

   // Advances the predictor by one accepted beat; returns 1 when a bin comes out.
   function automatic bit fft_step(logic cmd, logic signed [15:0] re, logic signed [15:0] im,
                                   output bin_t res);
      int l, n, idx;
      l = used_log2();
      n = 1 << l;
      res = '0;
      if (cmd == CMD_LOAD) begin
         idx = load_cnt % NPTS;
         if (bins_ready) begin bins_ready = 0; drain_cnt = 0; end
         fft_re[idx] = re; fft_im[idx] = im;
         load_cnt++;
         if (load_cnt >= n) begin
            run_fft(n, l);
            load_cnt = 0; drain_cnt = 0; bins_ready = 1;
            n_frames++;
         end
         return 0;
      end
      if (!bins_ready) return 0;
      idx = drain_cnt % NPTS;
      res.last = (drain_cnt + 1) >= n;
      res.re = scale_bin(fft_re[idx], l, res.sat);
      res.im = scale_bin(fft_im[idx], l, res.sat);
      res.idx = idx[9:0];
      if (res.last) begin bins_ready = 0; drain_cnt = 0; end
      else drain_cnt++;
      return 1;
   endfunction

   // Sender: bursts of beats with random gaps between them.
   task automatic send_beat(logic cmd, logic signed [15:0] re, logic signed [15:0] im,
                            bit typed = 0, bit typed_has = 0, bin_t typed_bin = '0);
      int gap;
      bin_t res;
      bit got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sample_real <= re;
      req_sample_imag <= im;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (cmd == CMD_LOAD) n_loads++; else n_drains++;
      got = fft_step(cmd, re, im, res);
      if (typed) begin
         if (typed_has) bins_due.push_back(typed_bin);
      end else if (got) bins_due.push_back(res);
   endtask

   // Sender pause: every expected bin back, then time for a transform to finish.
   task automatic wait_idle();
      int l;
      req_valid <= 1'b0;
      burst_left = 0;
      while (bins_due.size() != 0) @(posedge clock);
      l = used_log2();
      repeat (((1 << l) * l) + (2 << l) + 5 * (l + 1) + 10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_LOG2_POINTS) cfg_log2 = data;
      else cfg_inverse = data[0];
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return -16'sh8000;
         default: return $urandom();
      endcase
   endfunction

   // Receiver stall pattern, with an occasional long hold-off on request
   int hold_cnt, stall_mode, mode_cnt;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt = 0; mode_cnt = 0; stall_mode = 0;
      end else begin
         if (hold_request) begin
            hold_cnt = 500;
            hold_request = 0;
         end
         if (mode_cnt == 0) begin
            mode_cnt = $urandom_range(16, 80);
            stall_mode = $urandom_range(0, 2);
         end
         mode_cnt--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= (mode_cnt % 3 == 0);
         endcase
      end
   end

   // Result checker and watchdog
   int idle_cycles;
   always @(posedge clock) begin
      bin_t want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            n_bins++;
            if (bins_due.size() == 0) begin
               $error("unexpected result beat, bin_index %0d", rsp_bin_index);
               err_cnt++;
            end else begin
               want = bins_due.pop_front();
               if (rsp_result_real !== want.re) begin
                  $error("result_real: expected %0d, got %0d", want.re, rsp_result_real);
                  err_cnt++;
               end
               if (rsp_result_imag !== want.im) begin
                  $error("result_imag: expected %0d, got %0d", want.im, rsp_result_imag);
                  err_cnt++;
               end
               if (rsp_bin_index !== want.idx) begin
                  $error("bin_index: expected %0d, got %0d", want.idx, rsp_bin_index);
                  err_cnt++;
               end
               if (rsp_last_bin !== want.last) begin
                  $error("last_bin: expected %0d, got %0d", want.last, rsp_last_bin);
                  err_cnt++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated: expected %0d, got %0d", want.sat, rsp_saturated);
                  err_cnt++;
               end
            end
         end
      end
   end

   // Directed table: drains with nothing pending, full-scale DC frames that clip,
   // a length cut mid-drain, length 0 (runs as 2 points) and inverse direction.
   localparam bin_t BIN_POS_DC = '{re: 16'sh7fff, im: 16'sh7fff, idx: 0, last: 0, sat: 1};
   localparam bin_t BIN_NEG_DC = '{re: -16'sh8000, im: -16'sh8000, idx: 0, last: 0, sat: 1};
   row_t dir_rows[] = '{
      '{ROW_BEAT_NONE, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT_NONE, CMD_DRAIN, -1, -1, '0},
      '{ROW_CFG, CSR_LOG2_POINTS, 2, 0, '0},
      '{ROW_BEAT, CMD_LOAD, 16'sh7fff, 16'sh7fff, '0},
      '{ROW_BEAT, CMD_LOAD, 16'sh7fff, 16'sh7fff, '0},
      '{ROW_BEAT, CMD_LOAD, 16'sh7fff, 16'sh7fff, '0},
      '{ROW_BEAT, CMD_LOAD, 16'sh7fff, 16'sh7fff, '0},
      '{ROW_BEAT_BIN, CMD_DRAIN, 0, 0, BIN_POS_DC},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT_NONE, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT, CMD_LOAD, -16'sh8000, -16'sh8000, '0},
      '{ROW_BEAT, CMD_LOAD, -16'sh8000, -16'sh8000, '0},
      '{ROW_BEAT, CMD_LOAD, -16'sh8000, -16'sh8000, '0},
      '{ROW_BEAT, CMD_LOAD, -16'sh8000, -16'sh8000, '0},
      '{ROW_BEAT_BIN, CMD_DRAIN, 0, 0, BIN_NEG_DC},
      '{ROW_CFG, CSR_LOG2_POINTS, 0, 0, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT, CMD_LOAD, 16'sh1234, -16'sh4321, '0},
      '{ROW_BEAT, CMD_LOAD, -16'sh0001, 16'sh5555, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_CFG, CSR_INVERSE, 1, 0, '0},
      '{ROW_CFG, CSR_LOG2_POINTS, 1, 0, '0},
      '{ROW_BEAT, CMD_LOAD, 16'sh7fff, -16'sh8000, '0},
      '{ROW_BEAT, CMD_LOAD, -16'sh8000, 16'sh7fff, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0},
      '{ROW_BEAT, CMD_DRAIN, 0, 0, '0}
   };

   int phase_log2[] = '{3, 1, 4, 2, 5, 0, 15, 3, 6, 2, 4, 1};
   int phase_inv[]  = '{0, 1, 0, 1, 1, 0, 1,  1, 0, 0, 1, 0};

   initial begin
      int n, k, budget, start_items;
      bit big_done;
      reset = 1'b1;
      csr_write = 1'b0; csr_index = '0; csr_data = '0;
      req_valid = 1'b0; req_command = CMD_LOAD;
      req_sample_real = '0; req_sample_imag = '0;
      err_cnt = 0; n_loads = 0; n_drains = 0; n_bins = 0; n_frames = 0;
      burst_left = 0; hold_request = 0; idle_cycles = 0;
      load_cnt = 0; drain_cnt = 0; bins_ready = 0;
      cfg_log2 = LOG2_POINTS_RESET; cfg_inverse = 1'b0;
      build_cos_rom();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG)
            write_csr(dir_rows[i].cmd, dir_rows[i].re[3:0]);
         else
            send_beat(dir_rows[i].cmd, dir_rows[i].re, dir_rows[i].im,
                      dir_rows[i].kind != ROW_BEAT, dir_rows[i].kind == ROW_BEAT_BIN,
                      dir_rows[i].bin);
      end

      big_done = 0;
      start_items = n_loads + n_drains;
      for (int p = 0; n_loads + n_drains - start_items < 450; p = (p + 1) % phase_log2.size()) begin
         // a longer transform must not open up bins that were never loaded
         if (bins_ready && phase_log2[p] > used_log2()) begin
            while (bins_ready) send_beat(CMD_DRAIN, 0, 0);
         end
         if (phase_log2[p] == 15 && big_done) continue;
         write_csr(CSR_LOG2_POINTS, phase_log2[p]);
         write_csr(CSR_INVERSE, phase_inv[p]);
         n = 1 << used_log2();
         budget = n_loads + n_drains + 40;
         if (p == 6) big_done = 1;
         do begin
            case ($urandom_range(0, 9))
               0: send_beat(CMD_DRAIN, $urandom(), $urandom());
               1: repeat ($urandom_range(1, n)) send_beat(CMD_LOAD, rand_sample(), rand_sample());
               2: begin
                  // partial drain, next load drops the rest of the frame
                  while (load_cnt != 0 || !bins_ready)
                     send_beat(CMD_LOAD, rand_sample(), rand_sample());
                  repeat ($urandom_range(0, n - 1)) send_beat(CMD_DRAIN, 0, 0);
               end
               default: begin
                  k = $urandom_range(0, 3);
                  while (load_cnt != 0 || !bins_ready)
                     send_beat(CMD_LOAD, k == 0 ? 16'sh4000 : rand_sample(),
                               k == 0 ? -16'sh4000 : rand_sample());
                  if (p == 2 && n_bins < 200) hold_request = 1;
                  while (bins_ready) send_beat(CMD_DRAIN, $urandom(), $urandom());
               end
            endcase
         end while (n_loads + n_drains < budget && phase_log2[p] != 15);
      end

      req_valid <= 1'b0;
      while (bins_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d loads and %0d drains over %0d frames, %0d result beats checked.",
               n_loads, n_drains, n_frames, n_bins);
      $display("Lengths 2 to 1024 points, both directions, clipping and abandoned frames.");
      if (err_cnt == 0 && bins_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
